### hdl/cor_pkg.sv
// Package for the circle overlap resolver: table depth, widths, field types.
// No dependencies.
`default_nettype none
package cor_pkg;
    localparam int MaxParticles = 64;
    localparam int IdxW = $clog2(MaxParticles);
    localparam int CntW = $clog2(MaxParticles + 1);
    localparam int PosW = 32;
    localparam int RadW = 31;
    localparam int OutIdxW = 6;
endpackage
`default_nettype wire

### hdl/circle_overlap_resolver.sv
// Circle overlap resolver: loads particles, resolves every pair, streams positions.
// Depends on cor_pkg and cor_ram.
//
//  channel | dir | tdata (low bit up)                     | tuser       | tlast
//  s_axis  | in  | pos_x[31:0] pos_y[63:32] radius[94:64] | is_dynamic  | last
//  m_axis  | out | index[5:0] out_x[37:6] out_y[69:38]    | -           | final_res
//
// A pair that overlaps runs a 32-step square root and two 66-step divisions, all on
// one shared subtract unit; a pair that the flags, the bounding box or the squared
// distance rejects skips them. The whole set costs N*(N-1)/2 pair visits, and input
// is not ready meanwhile. Output reads each particle through S_ORD and S_OWAIT, then
// offers it in S_OUT until downstream takes it.
// Reset clears the control state only; the stores need no clearing.
`default_nettype none
module circle_overlap_resolver
    import cor_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,   // pos_x, pos_y, radius, pad
    input  wire logic         s_axis_tuser,   // is_dynamic
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata,   // index, out_x, out_y, pad
    output logic              m_axis_tlast
);
    typedef enum logic [3:0] {
        S_LOAD, S_PAIR, S_RD, S_CHECK, S_SQ, S_SQRT, S_DIVSET, S_DIV, S_WR1, S_WR2,
        S_ORD, S_OWAIT, S_OUT
    } state_t;

    state_t           state_reg;
    logic [CntW-1:0]  count_reg;
    logic [IdxW-1:0]  i_reg, j_reg;
    logic [IdxW-1:0]  addr;
    logic             we;
    logic [95:0]      wdata, rdata;
    logic [95:0]      pi_reg;
    logic [95:0]      pj_reg;
    logic             rd_phase_reg;
    logic signed [33:0] dx_reg, dy_reg;
    logic [32:0]      ax_reg, ay_reg, rsum_reg;
    logic [63:0]      d2_reg, rem_reg, root_reg, bit_reg;
    logic [65:0]      num_reg, quo_reg;
    logic [65:0]      drem_reg;
    logic [33:0]      den_reg;
    logic [6:0]       step_reg;
    logic             axis_reg;
    logic [31:0]      mx_reg, my_reg;
    logic             di_reg, dj_reg;
    logic             half_reg;

    // add or subtract a move magnitude, clamp to the signed 32-bit range
    function automatic logic [31:0] sat_add(input logic [31:0] p, input logic [31:0] m,
                                            input logic sub);
        logic signed [33:0] s;
        s = sub ? ($signed({{2{p[31]}}, p}) - $signed({2'b00, m}))
                : ($signed({{2{p[31]}}, p}) + $signed({2'b00, m}));
        if (s > 34'sd2147483647)
            sat_add = 32'h7FFF_FFFF;
        else if (s < -34'sd2147483648)
            sat_add = 32'h8000_0000;
        else
            sat_add = s[31:0];
    endfunction

    // one RAM row: x, y, radius, dynamic
    cor_ram #(.Width(96), .Depth(MaxParticles)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    logic [31:0] xi, yi, xj, yj;
    always_comb
    begin
        xi = pi_reg[31:0];
        yi = pi_reg[63:32];
        xj = pj_reg[31:0];
        yj = pj_reg[63:32];
        we = 1'b0;
        addr = i_reg;
        wdata = rdata;
        case (state_reg)
            S_LOAD:
            begin
                addr = count_reg[IdxW-1:0];
                we = s_axis_tvalid && (count_reg < CntW'(MaxParticles));
                wdata = {s_axis_tuser, s_axis_tdata[94:0]};
            end
            S_PAIR: addr = i_reg;
            S_RD: addr = rd_phase_reg ? j_reg : i_reg;
            S_WR1:
            begin
                // i moves against the sign of the offset
                addr = i_reg;
                we = di_reg;
                wdata = {pi_reg[95:64], sat_add(yi, my_reg, !dy_reg[33]),
                         sat_add(xi, mx_reg, !dx_reg[33])};
            end
            S_WR2:
            begin
                addr = j_reg;
                we = dj_reg;
                wdata = {pj_reg[95:64], sat_add(yj, my_reg, dy_reg[33]),
                         sat_add(xj, mx_reg, dx_reg[33])};
            end
            S_ORD, S_OWAIT, S_OUT: addr = i_reg;
            default: addr = i_reg;
        endcase
    end

    // shared subtract for square root and division
    logic [65:0] sub_a, sub_b, sub_d;
    always_comb
    begin
        sub_a = 66'(rem_reg);
        sub_b = 66'(root_reg) + 66'(bit_reg);
        if (state_reg == S_DIV)
        begin
            sub_a = {drem_reg[64:0], num_reg[65]};
            sub_b = 66'(den_reg);
        end
        sub_d = sub_a - sub_b;
    end

    assign s_axis_tready = (state_reg == S_LOAD);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {2'b00, rdata[63:32], rdata[31:0], OutIdxW'(i_reg)};
    assign m_axis_tlast  = (CntW'(i_reg) + 1'b1 == count_reg);

    logic [32:0] ov;
    assign ov = rsum_reg - root_reg[32:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            rd_phase_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (s_axis_tvalid)
                    begin
                        logic [CntW-1:0] n;
                        n = (count_reg < CntW'(MaxParticles)) ? count_reg + 1'b1 : count_reg;
                        count_reg <= n;
                        if (s_axis_tlast)
                        begin
                            i_reg <= '0;
                            j_reg <= IdxW'(1);
                            state_reg <= (n > CntW'(1)) ? S_PAIR : S_ORD;
                            if (n == '0)
                                state_reg <= S_LOAD;
                        end
                    end
                end
                S_PAIR:
                begin
                    rd_phase_reg <= 1'b0;
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    // i data arrives first, then j
                    if (!rd_phase_reg)
                    begin
                        rd_phase_reg <= 1'b1;
                    end
                    else
                    begin
                        pi_reg <= rdata;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    logic signed [33:0] ddx, ddy;
                    logic [32:0] ax, ay, rs;
                    ddx = $signed({{2{rdata[31]}}, rdata[31:0]})
                        - $signed({{2{pi_reg[31]}}, pi_reg[31:0]});
                    ddy = $signed({{2{rdata[63]}}, rdata[63:32]})
                        - $signed({{2{pi_reg[63]}}, pi_reg[63:32]});
                    ax = ddx[33] ? 33'(-ddx) : 33'(ddx);
                    ay = ddy[33] ? 33'(-ddy) : 33'(ddy);
                    rs = 33'(pi_reg[94:64]) + 33'(rdata[94:64]);
                    // hold j, the read port moves on
                    pj_reg <= rdata;
                    dx_reg <= ddx;
                    dy_reg <= ddy;
                    ax_reg <= ax;
                    ay_reg <= ay;
                    rsum_reg <= rs;
                    di_reg <= pi_reg[95];
                    dj_reg <= rdata[95];
                    half_reg <= pi_reg[95] && rdata[95];
                    step_reg <= '0;
                    if ((!pi_reg[95] && !rdata[95]) || ax >= rs || ay >= rs)
                        state_reg <= S_WR2;
                    else
                        state_reg <= S_SQ;
                    mx_reg <= '0;
                    my_reg <= '0;
                end
                S_SQ:
                begin
                    // ax, ay < 2^32, so these stay within 32x32 products
                    if (step_reg == 7'd0)
                    begin
                        d2_reg <= ax_reg[31:0] * ax_reg[31:0];
                        step_reg <= 7'd1;
                    end
                    else if (step_reg == 7'd1)
                    begin
                        rem_reg <= ay_reg[31:0] * ay_reg[31:0];
                        step_reg <= 7'd2;
                    end
                    else
                    begin
                        logic [64:0] s;
                        logic [65:0] rr;
                        s = 65'(d2_reg) + 65'(rem_reg);
                        rr = 66'(rsum_reg) * 66'(rsum_reg);
                        if (s[64] || 66'(s) >= rr || s == '0)
                        begin
                            state_reg <= S_WR2;
                        end
                        else
                        begin
                            rem_reg <= s[63:0];
                            root_reg <= '0;
                            bit_reg <= 64'h4000_0000_0000_0000;
                            step_reg <= '0;
                            state_reg <= S_SQRT;
                        end
                    end
                end
                S_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        axis_reg <= 1'b0;
                        state_reg <= S_DIVSET;
                    end
                    else
                    begin
                        if (!sub_d[65])
                        begin
                            rem_reg <= sub_d[63:0];
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            root_reg <= root_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_DIVSET:
                begin
                    logic [33:0] den;
                    den = half_reg ? {root_reg[32:0], 1'b0} : {1'b0, root_reg[32:0]};
                    den_reg <= den;
                    num_reg <= 66'(ov) * 66'(axis_reg ? ay_reg : ax_reg) + 66'(den >> 1);
                    drem_reg <= '0;
                    quo_reg <= '0;
                    step_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    logic [65:0] q;
                    if (!sub_d[65])
                        drem_reg <= sub_d;
                    else
                        drem_reg <= {drem_reg[64:0], num_reg[65]};
                    q = {quo_reg[64:0], !sub_d[65]};
                    quo_reg <= q;
                    num_reg <= num_reg << 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 7'd65)
                    begin
                        logic [31:0] m;
                        m = (q > 66'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                        if (!axis_reg)
                        begin
                            mx_reg <= m;
                            axis_reg <= 1'b1;
                            state_reg <= S_DIVSET;
                        end
                        else
                        begin
                            my_reg <= m;
                            state_reg <= S_WR1;
                        end
                    end
                end
                S_WR1:
                begin
                    if (!dj_reg)
                        state_reg <= S_WR2;
                    else
                        state_reg <= S_WR2;
                end
                S_WR2:
                begin
                    // advance to the next pair
                    if (CntW'(j_reg) + 1'b1 < count_reg)
                    begin
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_PAIR;
                    end
                    else if (CntW'(i_reg) + 2'd2 < count_reg)
                    begin
                        i_reg <= i_reg + 1'b1;
                        j_reg <= i_reg + 2'd2;
                        state_reg <= S_PAIR;
                    end
                    else
                    begin
                        i_reg <= '0;
                        state_reg <= S_ORD;
                    end
                end
                S_ORD: state_reg <= S_OWAIT;
                S_OWAIT: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        if (m_axis_tlast)
                        begin
                            count_reg <= '0;
                            i_reg <= '0;
                            j_reg <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            state_reg <= S_ORD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

### hdl/cor_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module cor_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### hdl/cor_checker.sv
// Port-level checks for the circle overlap resolver, bound to the top level.
// Depends on cor_pkg.
`default_nettype none
module cor_checker
    import cor_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("load and output overlap");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped under stall");
    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("not ready after output run");
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
        else $error("output run cut short");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && !s_axis_tvalid |=> s_axis_tready)
        else $error("input ready dropped while idle");
endmodule

bind circle_overlap_resolver cor_checker u_cor_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

### sim/circle_overlap_resolver_tb.sv
// Testbench for circle_overlap_resolver: loads particle sets over the input stream and
// checks every resolved position against a behavioral predictor of the pair resolution.
// Depends on cor_pkg and the RTL of the block.
`default_nettype none
module circle_overlap_resolver_tb
    import cor_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PosW-1:0] px;
        logic [PosW-1:0] py;
        logic [RadW-1:0] rad;
        logic            dyn;
        logic            lst;
    } particle_t;

    typedef struct packed {
        logic [OutIdxW-1:0] idx;
        logic [PosW-1:0]    ox;
        logic [PosW-1:0]    oy;
        logic               fin;
    } position_t;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    localparam int HoldLen = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    particle_t  pending_particles[$];
    position_t  expected_positions[$];
    idle_mode_t idle_mode;
    int         error_count = 0;
    int         hold_cycles;
    bit         hold_start;

    // predictor table
    longint px_tab[MaxParticles];
    longint py_tab[MaxParticles];
    longint rad_tab[MaxParticles];
    bit     dyn_tab[MaxParticles];
    int     loaded = 0;

    circle_overlap_resolver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint push_amount(longint unsigned ov, longint d, longint unsigned den);
        longint unsigned ad;
        longint unsigned q;
        ad = (d < 0) ? longint'(-d) : longint'(d);
        q = (ov * ad + (den >> 1)) / den;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void separate_pair(int i, int j);
        longint          dx;
        longint          dy;
        longint          hx;
        longint          hy;
        longint unsigned adx;
        longint unsigned ady;
        longint unsigned rs;
        longint unsigned sqx;
        longint unsigned d2;
        longint unsigned root_d;
        longint unsigned ov;
        if (!dyn_tab[i] && !dyn_tab[j])
            return;
        dx = px_tab[j] - px_tab[i];
        dy = py_tab[j] - py_tab[i];
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        rs = rad_tab[i] + rad_tab[j];
        if (adx >= rs || ady >= rs)
            return;
        sqx = adx * adx;
        d2 = sqx + ady * ady;
        if (d2 < sqx || d2 >= rs * rs || d2 == 0)
            return;
        root_d = root_floor(d2);
        ov = rs - root_d;
        if (!dyn_tab[i])
        begin
            px_tab[j] = clamp32(px_tab[j] + push_amount(ov, dx, root_d));
            py_tab[j] = clamp32(py_tab[j] + push_amount(ov, dy, root_d));
        end
        else if (!dyn_tab[j])
        begin
            px_tab[i] = clamp32(px_tab[i] - push_amount(ov, dx, root_d));
            py_tab[i] = clamp32(py_tab[i] - push_amount(ov, dy, root_d));
        end
        else
        begin
            hx = push_amount(ov, dx, root_d * 2);
            hy = push_amount(ov, dy, root_d * 2);
            px_tab[i] = clamp32(px_tab[i] - hx);
            py_tab[i] = clamp32(py_tab[i] - hy);
            px_tab[j] = clamp32(px_tab[j] + hx);
            py_tab[j] = clamp32(py_tab[j] + hy);
        end
    endfunction

    // Runs on every accepted input transfer.
    function automatic void predict_positions(particle_t p);
        position_t r;
        if (loaded < MaxParticles)
        begin
            px_tab[loaded] = longint'(signed'(p.px));
            py_tab[loaded] = longint'(signed'(p.py));
            rad_tab[loaded] = longint'(p.rad);
            dyn_tab[loaded] = p.dyn;
            loaded++;
        end
        if (!p.lst)
            return;
        for (int i = 0; i < loaded; i++)
            for (int j = i + 1; j < loaded; j++)
                separate_pair(i, j);
        for (int k = 0; k < loaded; k++)
        begin
            r.idx = k[OutIdxW-1:0];
            r.ox = px_tab[k][31:0];
            r.oy = py_tab[k][31:0];
            r.fin = (k + 1 == loaded);
            expected_positions.push_back(r);
        end
        loaded = 0;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("circle_overlap_resolver_tb: FAIL");
        $finish;
    end

    function automatic bit idle_roll(bit send_side);
        case (idle_mode)
            IDLE_SEND: return send_side && ($urandom_range(99) < 73);
            IDLE_RECV: return !send_side && ($urandom_range(99) < 73);
            IDLE_BOTH: return $urandom_range(99) < 11;
            default:   return 1'b0;
        endcase
    endfunction

    // Driver: hold the item until accepted, then advance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
            s_axis_tlast <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_positions(pending_particles.pop_front());
            if ((!s_axis_tvalid || s_axis_tready) || 1'b0)
            begin
                if (pending_particles.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)
                    && !idle_roll(1'b1) && pending_particles.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {1'b0, pending_particles[0].rad,
                                     pending_particles[0].py, pending_particles[0].px};
                    s_axis_tuser <= pending_particles[0].dyn;
                    s_axis_tlast <= pending_particles[0].lst;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver stall: count down once started.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cycles <= 0;
        else if (hold_start)
            hold_cycles <= HoldLen;
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // Monitor and stall generator.
    always @(posedge clk or negedge rst_n)
    begin
        position_t got;
        position_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.idx = m_axis_tdata[5:0];
                got.ox = m_axis_tdata[37:6];
                got.oy = m_axis_tdata[69:38];
                got.fin = m_axis_tlast;
                if (expected_positions.size() == 0)
                    report_mismatch("unexpected transfer", 64'(got.idx), 64'hx);
                else
                begin
                    want = expected_positions.pop_front();
                    if (got.idx !== want.idx)
                        report_mismatch("index", 64'(got.idx), 64'(want.idx));
                    if (got.ox !== want.ox)
                        report_mismatch("out_x", 64'(got.ox), 64'(want.ox));
                    if (got.oy !== want.oy)
                        report_mismatch("out_y", 64'(got.oy), 64'(want.oy));
                    if (got.fin !== want.fin)
                        report_mismatch("final_res", 64'(got.fin), 64'(want.fin));
                end
            end
            m_axis_tready <= !(hold_start || hold_cycles > 0) && !idle_roll(1'b0);
        end
    end

    function automatic particle_t random_particle(bit lst, int spread);
        particle_t p;
        int        mode;
        mode = $urandom_range(9);
        if (mode == 0)
        begin
            p.px = $urandom;
            p.py = $urandom;
            p.rad = 31'($urandom);
        end
        else
        begin
            // clustered near the origin so pairs overlap often
            p.px = 32'($signed($urandom_range(2 * spread)) - spread) <<< 16;
            p.py = 32'($signed($urandom_range(2 * spread)) - spread) <<< 16;
            p.px ^= 32'($urandom_range(16'hffff));
            p.py ^= 32'($urandom_range(16'hffff));
            p.rad = 31'($urandom_range(spread * 65536));
        end
        p.dyn = ($urandom_range(3) != 0);
        p.lst = lst;
        return p;
    endfunction

    task automatic queue_set(int n, int spread);
        for (int k = 0; k < n; k++)
            pending_particles.push_back(random_particle(k == n - 1, spread));
    endtask

    function automatic particle_t mk(logic [31:0] x, logic [31:0] y, logic [30:0] r,
                                     bit d, bit l);
        particle_t p;
        p.px = x;
        p.py = y;
        p.rad = r;
        p.dyn = d;
        p.lst = l;
        return p;
    endfunction

    task automatic drain();
        while (pending_particles.size() != 0 || s_axis_tvalid || expected_positions.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        idle_mode = IDLE_NONE;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // single particle; coincident dynamic centres; static against static
        pending_particles.push_back(mk(32'h7fffffff, 32'h80000000, 31'h7fffffff, 1, 1));
        pending_particles.push_back(mk(32'h00010000, 32'h00010000, 31'h00020000, 1, 0));
        pending_particles.push_back(mk(32'h00010000, 32'h00010000, 31'h00020000, 1, 1));
        pending_particles.push_back(mk(32'h0, 32'h0, 31'h00020000, 0, 0));
        pending_particles.push_back(mk(32'h00010000, 32'h0, 31'h00020000, 0, 1));
        // static against dynamic, dynamic pair, far pair
        pending_particles.push_back(mk(32'h0, 32'h0, 31'h00020000, 0, 0));
        pending_particles.push_back(mk(32'h00010000, 32'h00008000, 31'h00020000, 1, 0));
        pending_particles.push_back(mk(32'h00030000, 32'hffff0000, 31'h00018000, 1, 0));
        pending_particles.push_back(mk(32'h00300000, 32'h0, 31'h00010000, 1, 1));
        // saturation at the top and bottom of the range, huge radii
        pending_particles.push_back(mk(32'h7fff0000, 32'h80010000, 31'h7fffffff, 1, 0));
        pending_particles.push_back(mk(32'h7ffe0000, 32'h80020000, 31'h7fffffff, 0, 1));
        pending_particles.push_back(mk(32'h80000000, 32'h7fffffff, 31'h0, 1, 0));
        pending_particles.push_back(mk(32'h80000001, 32'h7ffffffe, 31'h1, 1, 1));
        drain();

        // table full: extra items ignored, last on an ignored item
        queue_set(70, 40);
        drain();

        // long downstream hold while the sender keeps going
        hold_start <= 1'b1;
        queue_set(12, 8);
        queue_set(10, 8);
        @(posedge clk);
        hold_start <= 1'b0;
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_mode = idle_mode_t'(ph);
            for (int s = 0; s < 8; s++)
                queue_set((s == 7) ? 14 : int'($urandom_range(1, 10)),
                          4 + int'($urandom_range(20)));
            drain();
        end

        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("circle_overlap_resolver_tb: PASS");
        else
            $display("circle_overlap_resolver_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

### circle_overlap_resolver.f
hdl/cor_pkg.sv
hdl/cor_ram.sv
hdl/circle_overlap_resolver.sv
hdl/cor_checker.sv
sim/circle_overlap_resolver_tb.sv
